// File: sv/iscp_response_frame_decoder_defines.svh
// assertion macros for the response frame decoder checker
`ifndef ISCP_RESPONSE_FRAME_DECODER_DEFINES_SVH
`define ISCP_RESPONSE_FRAME_DECODER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define IRFD_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("irfd check failed");
// next-cycle implication checked outside reset
`define IRFD_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("irfd check failed");
`endif

// File: sv/irfd_pkg.sv
// shared types, codes and tables for the response frame decoder
`timescale 1ns / 1ps
`default_nettype none
package irfd_pkg;
	localparam int MaxFrameDef = 128;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NONPRINT = 3'd1;
	localparam logic [2:0] ST_PREFIX   = 3'd2;
	localparam logic [2:0] ST_BADCMD   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [3:0] K_UNKNOWN = 4'd0;
	localparam logic [3:0] K_PWR = 4'd1;
	localparam logic [3:0] K_AMT = 4'd2;
	localparam logic [3:0] K_MVL = 4'd3;
	localparam logic [3:0] K_SLI = 4'd4;
	localparam logic [3:0] K_LMD = 4'd5;
	localparam logic [3:0] K_TFR = 4'd6;
	localparam logic [3:0] K_SWL = 4'd7;
	localparam logic [3:0] K_CTL = 4'd8;
	localparam logic [3:0] K_ADY = 4'd9;
	localparam logic [3:0] K_ADQ = 4'd10;
	localparam logic [3:0] K_ADV = 4'd11;
	localparam logic [3:0] K_FLD = 4'd12;

	// bass / treble capture: found marker, chars taken, two chars
	typedef struct packed {
		logic        found;
		logic [1:0]  cnt;
		logic [15:0] chars;
	} cap_t;

	// frame gather state handed to the decode stage
	typedef struct packed {
		logic        prefix_ok;
		logic        printable_ok;
		logic [23:0] cmd;
		logic [15:0] two;
		logic [7:0]  hex_acc;
		logic [1:0]  hex_flags;
		cap_t        bass;
		cap_t        treble;
	} frame_t;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= "0" && c <= "9") r = {1'b0, c[3:0]};
		else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
			r = {1'b0, c[3:0] + 4'd9};
		return r;
	endfunction

	function automatic cap_t cap_step(input cap_t c, input logic [7:0] b,
			input logic [7:0] marker);
		cap_t r;
		r = c;
		if (!c.found) begin
			if (b == marker) r = '{found: 1'b1, cnt: 2'd0, chars: 16'd0};
		end else if (c.cnt < 2'd2) begin
			r.cnt = c.cnt + 2'd1;
			r.chars = {c.chars[7:0], b};
		end
		return r;
	endfunction

	function automatic logic in_input_tab(input logic [15:0] t);
		logic r;
		case (t)
			"00", "01", "02", "03", "04", "05", "10", "20", "22", "23", "24", "25",
			"26", "30", "40", "55", "56", "57": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic in_mode_tab(input logic [15:0] t);
		logic r;
		case (t)
			"00", "01", "02", "03", "05", "06", "08", "09", "0A", "0B", "0C", "0D",
			"0E", "0F", "13", "16", "40", "42", "43", "44", "45", "50", "51", "52",
			"80", "81", "82", "83", "84", "85", "86", "89", "8A", "8B", "8C", "90",
			"94", "95", "96", "A0", "A1", "A2", "A3", "A4": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: sv/irfd_gather.sv
// per-byte frame gathering: fill count, prefix, printable, captures
`timescale 1ns / 1ps
`default_nettype none
module irfd_gather
	import irfd_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDef,
	localparam int CW = $clog2(MAX_FRAME + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    rx_byte,
	output logic               fire,
	output logic               overflow,
	output logic [CW-1:0]      fill,
	output frame_t             frame
);
	// empty frame: everything zero except the printable flag
	localparam frame_t FrameClr = frame_t'({2'b01, {($bits(frame_t) - 2){1'b0}}});

	logic [CW-1:0] fill_q;
	frame_t        fr_q, nx;
	logic          is_term, is_bang, clr;
	logic [4:0]    hd;
	logic [11:0]   acc;

	assign is_term  = rx_byte == 8'h0D || rx_byte == 8'h0A || rx_byte == 8'h1A;
	assign is_bang  = rx_byte == "!";
	assign fire     = is_term && fill_q != '0;
	assign overflow = !is_term && !is_bang && fill_q >= CW'(MAX_FRAME);
	assign clr      = is_term || is_bang || overflow;
	assign fill     = fill_q;
	assign frame    = fr_q;
	assign hd       = hex_val(rx_byte);
	assign acc      = {fr_q.hex_acc, 4'd0} + {8'd0, hd[3:0]};

	always_comb begin
		nx = fr_q;
		if (is_bang) begin
			nx = '0;
			nx.printable_ok = 1'b1;
			nx.prefix_ok = 1'b1;
		end else begin
			if (rx_byte < 8'h20 || rx_byte > 8'h7E) nx.printable_ok = 1'b0;
			if (fill_q == CW'(0)) nx.prefix_ok = 1'b0;
			else if (fill_q == CW'(1)) nx.prefix_ok = fr_q.prefix_ok && rx_byte == "1";
			else if (fill_q < CW'(5)) nx.cmd = {fr_q.cmd[15:0], rx_byte};
			else begin
				if (fill_q < CW'(7)) nx.two = {fr_q.two[7:0], rx_byte};
				if (!fr_q.hex_flags[1]) begin
					if (hd[4]) nx.hex_flags[1] = 1'b1;
					else begin
						nx.hex_acc = (acc > 12'd255) ? 8'd255 : acc[7:0];
						nx.hex_flags[0] = 1'b1;
					end
				end
				nx.bass = cap_step(fr_q.bass, rx_byte, "B");
				nx.treble = cap_step(fr_q.treble, rx_byte, "T");
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			fr_q <= FrameClr;
		end else if (take) begin
			if (clr && !is_bang) begin
				fill_q <= '0;
				fr_q <= FrameClr;
			end else begin
				fill_q <= is_bang ? CW'(1) : fill_q + CW'(1);
				fr_q <= nx;
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/irfd_decode.sv
// frame-end check and value decode, purely combinational
`timescale 1ns / 1ps
`default_nettype none
module irfd_decode
	import irfd_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDef,
	localparam int CW = $clog2(MAX_FRAME + 1)
) (
	input  wire logic [CW-1:0] fill,
	input  wire frame_t        frame,
	output logic [2:0]         status,
	output logic [3:0]         command_kind,
	output logic [23:0]        command_text,
	output logic [7:0]         value_length,
	output logic               primary_valid,
	output logic signed [8:0]  primary_value,
	output logic               secondary_valid,
	output logic signed [4:0]  secondary_value
);
	logic [3:0]  kind;
	logic        cmd_ok, two_ok, lv_ok, bt_ok, tt_ok;
	logic [CW-1:0] vl;
	logic [15:0] two;
	logic signed [5:0] lv;
	logic signed [4:0] bv, tv;
	logic [4:0]  hh, hl;

	function automatic logic cc_ok(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
	endfunction

	function automatic logic [5:0] level(input logic [15:0] t);
		// bit5 valid, bits 4:0 signed value
		logic [4:0] m;
		logic [5:0] r;
		r = 6'd0;
		m = hex_val(t[7:0]);
		if (t == "00") r = 6'b100000;
		else if ((t[15:8] == "+" || t[15:8] == "-") && !m[4] &&
				!(t[7:0] >= "a" && t[7:0] <= "f"))
			r = {1'b1, (t[15:8] == "-") ? 5'(-m) : m};
		return r;
	endfunction

	function automatic logic [5:0] tone(input cap_t c);
		logic [4:0] m;
		logic [5:0] r;
		r = 6'd0;
		m = (c.chars[7:0] == "A") ? 5'd10 :
			(c.chars[7:0] >= "0" && c.chars[7:0] <= "9") ? {1'b0, c.chars[3:0]} : 5'h1F;
		if (c.found && c.cnt == 2'd2) begin
			if (c.chars == "00") r = 6'b100000;
			else if ((c.chars[15:8] == "+" || c.chars[15:8] == "-") && m != 5'h1F && !m[0])
				r = {1'b1, (c.chars[15:8] == "-") ? 5'(-m) : m};
		end
		return r;
	endfunction

	assign two = frame.two;
	assign vl  = fill - CW'(5);
	assign two_ok = vl == CW'(2);
	assign cmd_ok = cc_ok(frame.cmd[23:16]) && cc_ok(frame.cmd[15:8]) && cc_ok(frame.cmd[7:0]);
	assign hh = hex_val(two[15:8]);
	assign hl = hex_val(two[7:0]);

	always_comb begin
		case (frame.cmd)
			"PWR": kind = K_PWR;
			"AMT": kind = K_AMT;
			"MVL": kind = K_MVL;
			"SLI": kind = K_SLI;
			"LMD": kind = K_LMD;
			"TFR": kind = K_TFR;
			"SWL": kind = K_SWL;
			"CTL": kind = K_CTL;
			"ADY": kind = K_ADY;
			"ADQ": kind = K_ADQ;
			"ADV": kind = K_ADV;
			"FLD": kind = K_FLD;
			default: kind = K_UNKNOWN;
		endcase
	end

	always_comb begin
		logic [5:0] l, b, t;
		l = level(two);
		b = tone(frame.bass);
		t = tone(frame.treble);
		lv = $signed(l[4:0]);
		lv_ok = l[5];
		bt_ok = b[5];
		bv = $signed(b[4:0]);
		tt_ok = t[5];
		tv = $signed(t[4:0]);
		status = ST_OK;
		command_kind = '0;
		command_text = '0;
		value_length = '0;
		primary_valid = 1'b0;
		primary_value = '0;
		secondary_valid = 1'b0;
		secondary_value = '0;
		if (!frame.printable_ok) status = ST_NONPRINT;
		else if (!frame.prefix_ok || fill < CW'(5)) status = ST_PREFIX;
		else if (!cmd_ok) status = ST_BADCMD;
		else begin
			command_kind = kind;
			command_text = frame.cmd;
			value_length = (32'(vl) > 32'd255) ? 8'd255 : 8'(vl);
			case (kind)
				K_PWR, K_AMT, K_ADY, K_ADQ:
					if (two_ok && (two == "00" || two == "01")) begin
						primary_valid = 1'b1;
						primary_value = {8'd0, two[0]};
					end
				K_MVL:
					if (frame.hex_flags[0]) begin
						primary_valid = 1'b1;
						primary_value = {1'b0, frame.hex_acc};
					end
				K_SLI, K_LMD:
					if (two_ok && ((kind == K_SLI) ? in_input_tab(two) : in_mode_tab(two))) begin
						primary_valid = 1'b1;
						primary_value = {1'b0, hh[3:0], hl[3:0]};
					end
				K_TFR: begin
					primary_valid = bt_ok;
					primary_value = bt_ok ? 9'(bv) : 9'sd0;
					secondary_valid = tt_ok;
					secondary_value = tt_ok ? tv : 5'sd0;
				end
				K_SWL, K_CTL:
					if (two_ok && lv_ok && lv <= 6'sd12 &&
							lv >= ((kind == K_SWL) ? -6'sd15 : -6'sd12)) begin
						primary_valid = 1'b1;
						primary_value = 9'(lv);
					end
				K_ADV:
					if (two_ok && two >= "00" && two <= "03") begin
						primary_valid = 1'b1;
						primary_value = {7'd0, two[1:0]};
					end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/iscp_response_frame_decoder.sv
// top level of the response frame decoder
//
// usage:
// - input channel rx_valid / rx_ready / rx_byte: one received uart byte
//   per request; '!' restarts a frame, cr, lf or 0x1a end it
// - output channel out_valid / out_ready plus the result fields: one
//   request per non-empty frame end, or per overflow (status 4)
// - an accepted byte updates the gather register; a frame-ending byte
//   has its result registered and visible in the cycle after acceptance
// - throughput is one byte per cycle unless a result waits on a stalled
//   receiver; one gather register feeds decode and one result register
// - rx_ready stays high while the result register is empty or is being
//   drained this cycle; while a result waits on a stalled receiver every
//   byte is held back, whether it ends a frame or not
// - reset (arst_n low) empties the frame buffer and the result register
`timescale 1ns / 1ps
`default_nettype none
module iscp_response_frame_decoder
	import irfd_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	input  wire logic [7:0]        rx_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic [3:0]             command_kind,
	output logic [23:0]            command_text,
	output logic [7:0]             value_length,
	output logic                   primary_valid,
	output logic signed [8:0]      primary_value,
	output logic                   secondary_valid,
	output logic signed [4:0]      secondary_value
);
	localparam int CW = $clog2(MAX_FRAME + 1);

	logic          take, fire, ovf;
	logic [CW-1:0] fill;
	frame_t        frame;
	logic [2:0]    d_status;
	logic [3:0]    d_kind;
	logic [23:0]   d_text;
	logic [7:0]    d_len;
	logic          d_pv, d_sv;
	logic signed [8:0] d_p;
	logic signed [4:0] d_s;

	// result slot free now or freed this cycle
	assign rx_ready = !out_valid || out_ready;
	assign take = rx_valid && rx_ready;

	irfd_gather #(.MAX_FRAME(MAX_FRAME)) u_gather (
		.clk, .arst_n, .take, .rx_byte,
		.fire, .overflow(ovf), .fill, .frame
	);

	// decode looks at the gathered frame; valid when fire is set
	irfd_decode #(.MAX_FRAME(MAX_FRAME)) u_decode (
		.fill, .frame,
		.status(d_status), .command_kind(d_kind), .command_text(d_text),
		.value_length(d_len), .primary_valid(d_pv), .primary_value(d_p),
		.secondary_valid(d_sv), .secondary_value(d_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (take && (fire || ovf)) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (take && (fire || ovf)) begin
			if (ovf) begin
				status <= ST_OVERFLOW;
				command_kind <= '0;
				command_text <= '0;
				value_length <= '0;
				primary_valid <= 1'b0;
				primary_value <= '0;
				secondary_valid <= 1'b0;
				secondary_value <= '0;
			end else begin
				status <= d_status;
				command_kind <= d_kind;
				command_text <= d_text;
				value_length <= d_len;
				primary_valid <= d_pv;
				primary_value <= d_p;
				secondary_valid <= d_sv;
				secondary_value <= d_s;
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/irfd_checker.sv
// port-level checks for the response frame decoder
`timescale 1ns / 1ps
`default_nettype none
`include "iscp_response_frame_decoder_defines.svh"
module irfd_checker
	import irfd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rx_valid,
	input wire logic        rx_ready,
	input wire logic [7:0]  rx_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [3:0]  command_kind,
	input wire logic        primary_valid,
	input wire logic        secondary_valid
);
	`IRFD_ASSERT_IMP(a_bad_status_clean, clk, arst_n,
		out_valid && status != ST_OK, command_kind == K_UNKNOWN && !primary_valid)
	`IRFD_ASSERT_IMP(a_sec_tone_only, clk, arst_n,
		out_valid && secondary_valid, command_kind == K_TFR)
	`IRFD_ASSERT_NXT(a_bang_no_result, clk, arst_n,
		rx_valid && rx_ready && rx_byte == "!" && !(out_valid && !out_ready), !out_valid)
	`IRFD_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, rx_ready)
endmodule
bind iscp_response_frame_decoder irfd_checker u_irfd_checker (
	.clk, .arst_n, .rx_valid, .rx_ready, .rx_byte, .out_valid, .out_ready,
	.status, .command_kind, .primary_valid, .secondary_valid
);
`default_nettype wire

// File: test/iscp_response_frame_decoder_tb.sv
// testbench for the response frame decoder: directed and random frames checked against a predictor
`timescale 1ns / 1ps
module iscp_response_frame_decoder_tb;
	import irfd_pkg::*;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        kind;
		logic [23:0]       text;
		logic [7:0]        vlen;
		logic              pv;
		logic signed [8:0] pval;
		logic              sv;
		logic signed [4:0] sval;
	} frame_result_t;

	localparam int ExpDepth = 1024;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic [7:0] rx_byte = 8'd0;
	logic out_ready = 1'b0;
	logic rx_ready, out_valid;
	logic [2:0] status;
	logic [3:0] command_kind;
	logic [23:0] command_text;
	logic [7:0] value_length;
	logic primary_valid, secondary_valid;
	logic signed [8:0] primary_value;
	logic signed [4:0] secondary_value;

	int error_count = 0;
	longint cycle_count = 0;
	bit out_busy = 1'b1;
	bit in_busy = 1'b1;
	// ring of expected results, written by the predictor, read by the checker
	frame_result_t expected_frames[0:ExpDepth-1];
	int exp_wr = 0;
	int exp_rd = 0;

	// predictor copy of the gather state
	int unsigned held;
	bit pfx_ok, prn_ok;
	logic [23:0] cmd_chars;
	logic [15:0] val_chars;
	int unsigned hex_acc;
	logic [1:0] hex_flags;
	logic [18:0] bass_cap, treble_cap;

	iscp_response_frame_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .command_kind(command_kind), .command_text(command_text),
		.value_length(value_length), .primary_valid(primary_valid),
		.primary_value(primary_value), .secondary_valid(secondary_valid),
		.secondary_value(secondary_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void clear_gather();
		held = 0; pfx_ok = 0; prn_ok = 1; cmd_chars = 0; val_chars = 0;
		hex_acc = 0; hex_flags = 0; bass_cap = 0; treble_cap = 0;
	endfunction

	function automatic void queue_expected(frame_result_t r);
		expected_frames[exp_wr % ExpDepth] = r;
		exp_wr++;
	endfunction

	function automatic int digit_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	// marker capture: bit 18 found, bits 17:16 count, bits 15:0 chars
	function automatic logic [18:0] tone_capture(logic [18:0] cap, logic [7:0] b,
			logic [7:0] marker);
		if (!cap[18]) return (b == marker) ? 19'h40000 : cap;
		if (cap[17:16] < 2) return {1'b1, cap[17:16] + 2'd1, cap[7:0], b};
		return cap;
	endfunction

	function automatic bit tone_value(logic [18:0] cap, output int v);
		logic [7:0] s, m;
		int mag;
		s = cap[15:8]; m = cap[7:0]; v = 0;
		if (!cap[18] || cap[17:16] != 2) return 0;
		if (cap[15:0] == "00") return 1;
		if (s != "+" && s != "-") return 0;
		if (m == "A") mag = 10;
		else if (m >= "0" && m <= "9") mag = m - "0";
		else return 0;
		if (mag % 2) return 0;
		v = (s == "-") ? -mag : mag;
		return 1;
	endfunction

	function automatic bit level_value(logic [15:0] two, output int v);
		int mag;
		v = 0;
		if (two == "00") return 1;
		if (two[15:8] != "+" && two[15:8] != "-") return 0;
		if (two[7:0] >= "0" && two[7:0] <= "9") mag = two[7:0] - "0";
		else if (two[7:0] >= "A" && two[7:0] <= "F") mag = two[7:0] - "A" + 10;
		else return 0;
		v = (two[15:8] == "-") ? -mag : mag;
		return 1;
	endfunction

	function automatic bit cmd_char_ok(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
	endfunction

	function automatic frame_result_t decode_frame();
		frame_result_t r;
		int vl, p, s, lv;
		bit two_ok;
		r = '0; p = 0; s = 0;
		if (!prn_ok) begin r.status = ST_NONPRINT; return r; end
		if (!pfx_ok || held < 5) begin r.status = ST_PREFIX; return r; end
		if (!cmd_char_ok(cmd_chars[23:16]) || !cmd_char_ok(cmd_chars[15:8]) ||
				!cmd_char_ok(cmd_chars[7:0])) begin
			r.status = ST_BADCMD;
			return r;
		end
		r.status = ST_OK;
		case (cmd_chars)
			"PWR": r.kind = K_PWR; "AMT": r.kind = K_AMT; "MVL": r.kind = K_MVL;
			"SLI": r.kind = K_SLI; "LMD": r.kind = K_LMD; "TFR": r.kind = K_TFR;
			"SWL": r.kind = K_SWL; "CTL": r.kind = K_CTL; "ADY": r.kind = K_ADY;
			"ADQ": r.kind = K_ADQ; "ADV": r.kind = K_ADV; "FLD": r.kind = K_FLD;
			default: r.kind = K_UNKNOWN;
		endcase
		r.text = cmd_chars;
		vl = held - 5;
		r.vlen = vl > 255 ? 8'd255 : vl[7:0];
		two_ok = (vl == 2);
		case (r.kind)
			K_PWR, K_AMT, K_ADY, K_ADQ:
				if (two_ok && (val_chars == "00" || val_chars == "01")) begin
					r.pv = 1; p = val_chars[0];
				end
			K_MVL: if (hex_flags[0]) begin r.pv = 1; p = hex_acc; end
			K_SLI, K_LMD: begin
				if (two_ok && (r.kind == K_SLI ? in_input_tab(val_chars)
						: in_mode_tab(val_chars))) begin
					r.pv = 1;
					p = digit_of(val_chars[15:8]) * 16 + digit_of(val_chars[7:0]);
				end
			end
			K_TFR: begin
				r.pv = tone_value(bass_cap, p);
				r.sv = tone_value(treble_cap, s);
			end
			K_SWL, K_CTL:
				if (two_ok && level_value(val_chars, lv) &&
						lv >= (r.kind == K_SWL ? -15 : -12) && lv <= 12) begin
					r.pv = 1; p = lv;
				end
			K_ADV:
				if (two_ok && val_chars >= "00" && val_chars <= "03") begin
					r.pv = 1; p = val_chars - "00";
				end
			default: ;
		endcase
		r.pval = 9'(p);
		r.sval = 5'(s);
		return r;
	endfunction

	// advance the predictor by one accepted byte
	function automatic void predict_byte(logic [7:0] b);
		int d;
		if (b == 8'h0D || b == 8'h0A || b == 8'h1A) begin
			if (held != 0) begin
				queue_expected(decode_frame());
				clear_gather();
			end
			return;
		end
		if (b == "!") clear_gather();
		else if (held >= 128) begin
			frame_result_t r;
			r = '0;
			r.status = ST_OVERFLOW;
			queue_expected(r);
			clear_gather();
			return;
		end
		if (b < 8'h20 || b > 8'h7E) prn_ok = 0;
		if (held == 0) pfx_ok = (b == "!");
		else if (held == 1) pfx_ok = pfx_ok && (b == "1");
		else if (held < 5) cmd_chars = {cmd_chars[15:0], b};
		else begin
			if (held < 7) val_chars = {val_chars[7:0], b};
			if (!hex_flags[1]) begin
				d = digit_of(b);
				if (d < 0) hex_flags[1] = 1;
				else begin
					hex_acc = hex_acc * 16 + d;
					if (hex_acc > 255) hex_acc = 255;
					hex_flags[0] = 1;
				end
			end
			bass_cap = tone_capture(bass_cap, b, "B");
			treble_cap = tone_capture(treble_cap, b, "T");
		end
		held++;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			frame_result_t e;
			if (exp_wr == exp_rd) begin
				$error("unexpected result, status %0d", status);
				error_count++;
			end else begin
				e = expected_frames[exp_rd % ExpDepth];
				exp_rd++;
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status); error_count++;
				end
				if (command_kind !== e.kind) begin
					$error("command_kind exp %0d got %0d", e.kind, command_kind);
					error_count++;
				end
				if (command_text !== e.text) begin
					$error("command_text exp %h got %h", e.text, command_text);
					error_count++;
				end
				if (value_length !== e.vlen) begin
					$error("value_length exp %0d got %0d", e.vlen, value_length);
					error_count++;
				end
				if (primary_valid !== e.pv) begin
					$error("primary_valid exp %0d got %0d", e.pv, primary_valid);
					error_count++;
				end
				if (primary_value !== e.pval) begin
					$error("primary_value exp %0d got %0d", e.pval, primary_value);
					error_count++;
				end
				if (secondary_valid !== e.sv) begin
					$error("secondary_valid exp %0d got %0d", e.sv, secondary_valid);
					error_count++;
				end
				if (secondary_value !== e.sval) begin
					$error("secondary_value exp %0d got %0d", e.sval, secondary_value);
					error_count++;
				end
			end
		end
		out_ready <= out_busy ? ($urandom_range(0, 99) >= 29) : 1'b1;
	end

	// send one byte request, with random idle cycles ahead of it while in_busy is set
	task automatic send_byte(input logic [7:0] b);
		while (in_busy && $urandom_range(0, 99) < 29) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		predict_byte(b);
	endtask

	task automatic send_text(input string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic send_frame(input string s);
		send_text(s);
		send_byte(8'h0D);
	endtask

	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_flags();
		send_frame("!1PWR01"); send_frame("!1AMT00"); send_frame("!1ADY02");
		send_frame("!1ADQ01"); send_frame("!1ADV03"); send_frame("!1ADV04");
		send_frame("!1FLD4142");
	endtask

	task automatic test_values();
		send_frame("!1MVL3f"); send_frame("!1MVLFFFFx1"); send_frame("!1MVLzz");
		send_frame("!1SLI2B"); send_frame("!1SLI23"); send_frame("!1LMDA4");
		send_frame("!1SWL-F"); send_frame("!1CTL-D"); send_frame("!1CTL+C");
		send_frame("!1TFRB-AT+8"); send_frame("!1TFRB+3T0"); send_frame("!1XYZ");
	endtask

	task automatic test_errors();
		send_frame("!1PW");
		send_frame("!1p#R01");
		send_frame("xx!1PWR\x7f0");
		send_byte(8'h0A);
		send_text("!1MVL");
		send_byte(8'h80); send_byte(8'h1A);
		send_text("!2PWR00"); send_byte(8'h1A);
		send_text("!1");
		repeat (126) send_byte("7");
		send_byte("7");
		send_frame("1");
	endtask

	// random: mostly well-formed frames with random content
	task automatic test_random();
		string kinds[13] = '{"PWR", "AMT", "MVL", "SLI", "LMD", "TFR", "SWL", "CTL",
			"ADY", "ADQ", "ADV", "FLD", "Q9Z"};
		string vchars = "0123456789ABCDEFabcdef+-TB ";
		int n, len, r;
		n = 0;
		while (n < 140) begin
			if (n > 30 && n < 100) in_busy = 0; else in_busy = 1;
			out_busy = in_busy;
			r = $urandom_range(0, 9);
			if (r < 8) begin
				send_text({"!1", kinds[$urandom_range(0, 12)]});
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 2;
				repeat (len) send_byte(vchars[$urandom_range(0, vchars.len() - 1)]);
				n += 5 + len;
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
				n += 3;
			end
			send_byte(($urandom_range(0, 2) == 0) ? 8'h0A : 8'h0D);
			n++;
			if (n > 110 && n < 125) wait_drained();
		end
		in_busy = 1; out_busy = 1;
	endtask

	initial begin
		clear_gather();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_flags();
		test_values();
		test_errors();
		wait_drained();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
